[design/assert_macros.svh]
// Assertion helper macros used by the RTL (barp_back)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that a property holds on every clock edge, off during reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assert that a property holds on every clock edge, also during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/barp_pkg.sv]
// ----------------------------------------------------------------------------
// barp_pkg
// Types, constants and decode functions for the bill acceptor reply parser.
// ----------------------------------------------------------------------------
package barp_pkg;

    localparam int MAX_ERROR_ENTRIES_DEF  = 10;
    localparam int MAX_REJECT_ENTRIES_DEF = 3;

    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_DC1 = 8'h11;
    localparam logic [7:0] CH_DC3 = 8'h13;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] NONE_VAL = 8'hFF;
    localparam logic [15:0] EMPTY_DENOM = 16'd888;

    localparam logic [1:0] HS_NONE = 2'd0;
    localparam logic [1:0] HS_ACK  = 2'd1;
    localparam logic [1:0] HS_DC3  = 2'd2;
    localparam logic [1:0] HS_DC1  = 2'd3;

    localparam logic [1:0] FR_IDLE  = 2'd0;
    localparam logic [1:0] FR_TEXT  = 2'd1;
    localparam logic [1:0] FR_CHECK = 2'd2;
    localparam logic [1:0] FR_DONE  = 2'd3;

    localparam logic [0:0] CFG_EXPECTED_CMD  = 1'd0;
    localparam logic [0:0] CFG_TIMEOUT_TICKS = 1'd1;

    // Byte classes produced by the front end
    localparam logic [2:0] CL_NONE  = 3'd0;
    localparam logic [2:0] CL_START = 3'd1;
    localparam logic [2:0] CL_TICK  = 3'd2;
    localparam logic [2:0] CL_HS    = 3'd3;
    localparam logic [2:0] CL_STX   = 3'd4;
    localparam logic [2:0] CL_ETX   = 3'd5;
    localparam logic [2:0] CL_TEXT  = 3'd6;
    localparam logic [2:0] CL_OTHER = 3'd7;

    // Letter slots: 0..6 values, 7 E, 8 R, 9 none
    localparam logic [3:0] SLOT_E    = 4'd7;
    localparam logic [3:0] SLOT_R    = 4'd8;
    localparam logic [3:0] SLOT_NONE = 4'd9;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status_code;
        logic [7:0]  accept_state;
        logic [7:0]  denom_index;
        logic [7:0]  note_count;
        logic [31:0] misc_status;
        logic [7:0]  error_classes;
        logic [3:0]  error_count;
        logic [1:0]  reject_count;
        logic [15:0] work_mode;
        logic [15:0] denomination;
    } out_item_t;

    // Classified item passed from front to back
    typedef struct packed {
        logic [2:0] cls;
        logic [1:0] hs;
        logic [7:0] ch;
    } cls_item_t;

    function automatic logic [3:0] letter_slot(input logic [7:0] c);
        logic [3:0] s;
        unique case (c)
            8'h41: s = 4'd0;
            8'h44: s = 4'd1;
            8'h4C: s = 4'd2;
            8'h4E: s = 4'd3;
            8'h50: s = 4'd4;
            8'h53: s = 4'd5;
            8'h57: s = 4'd6;
            8'h45: s = SLOT_E;
            8'h52: s = SLOT_R;
            default: s = SLOT_NONE;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
        else v = 4'd0;
        return v;
    endfunction

    function automatic logic [7:0] error_class_bit(input logic [7:0] code);
        logic [7:0] b;
        unique case (code)
            8'h01, 8'h02, 8'h04, 8'h05: b = 8'h01;
            8'h10: b = 8'h02;
            8'h0F: b = 8'h04;
            8'h54: b = 8'h08;
            8'h55: b = 8'h10;
            8'h56: b = 8'h20;
            8'h62: b = 8'h40;
            8'h82: b = 8'h80;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[design/barp_front.sv]
// ----------------------------------------------------------------------------
// barp_front
// Classifies input items and pushes them into a two-entry queue.
// ----------------------------------------------------------------------------
module barp_front
    import barp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      q_valid,
    input  logic      q_ready,
    output cls_item_t q_data
);

    cls_item_t  cls_item;
    cls_item_t  mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       push, pop;
    logic [7:0] b;

    // Classify one item
    always_comb begin
        b = s_data.rx_byte;
        cls_item.ch = b;
        cls_item.hs = HS_NONE;
        unique case (s_data.op)
            OP_BYTE: begin
                if (b == CH_ACK) begin
                    cls_item.cls = CL_HS;
                    cls_item.hs = HS_ACK;
                end else if (b == CH_DC3) begin
                    cls_item.cls = CL_HS;
                    cls_item.hs = HS_DC3;
                end else if (b == CH_DC1) begin
                    cls_item.cls = CL_HS;
                    cls_item.hs = HS_DC1;
                end else if (b == CH_STX) begin
                    cls_item.cls = CL_STX;
                end else if (b == CH_ETX) begin
                    cls_item.cls = CL_ETX;
                end else if ((b >= 8'h20 && b <= 8'h39) || (b >= 8'h40 && b <= 8'h5A)) begin
                    cls_item.cls = CL_TEXT;
                end else begin
                    cls_item.cls = CL_OTHER;
                end
            end
            OP_TICK:  cls_item.cls = CL_TICK;
            OP_START: cls_item.cls = CL_START;
            default:  cls_item.cls = CL_NONE;
        endcase
    end

    assign s_ready  = (cnt_reg != 2'd2);
    assign push     = s_valid && s_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_data   = mem_reg[rd_ptr_reg];
    assign cnt_next = cnt_reg + 2'(push) - 2'(pop);

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= cls_item;
        end
    end

    // Queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

endmodule

[design/barp_back.sv]
// ----------------------------------------------------------------------------
// barp_back
// Runs the parse state and emits a result into an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module barp_back
    import barp_pkg::*;
#(
    parameter int MAX_ERROR_ENTRIES  = MAX_ERROR_ENTRIES_DEF,
    parameter int MAX_REJECT_ENTRIES = MAX_REJECT_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [3:0]  expected_cmd,
    input  logic [15:0] timeout_ticks,
    input  logic        q_valid,
    output logic        q_ready,
    input  cls_item_t   q_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    localparam logic [3:0] ERR_MAX = 4'(MAX_ERROR_ENTRIES);
    localparam logic [1:0] REJ_MAX = 2'(MAX_REJECT_ENTRIES);

    logic [1:0]  hs_reg, hs_next;
    logic [1:0]  fr_reg, fr_next;
    logic        fin_reg, fin_next;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  letter_reg, letter_next;
    logic [7:0]  hex_reg, hex_next;
    logic [7:0]  gv_reg [7];
    logic [7:0]  gv_next [7];
    logic [3:0]  err_reg, err_next;
    logic [1:0]  rej_reg, rej_next;
    logic [7:0]  cls_reg, cls_next;
    logic [15:0] mode_reg, mode_next;
    logic [15:0] den_reg, den_next;
    logic        pfx_reg, pfx_next;
    logic        ndone_reg, ndone_next;
    logic [15:0] idle_reg, idle_next;
    logic        mv_reg;
    out_item_t   out_reg, out_next;
    logic        emit;
    logic        take;
    logic        match;
    logic [3:0]  slot, gslot;
    logic [1:0]  sub;
    logic [7:0]  c;
    logic [19:0] dprod;

    assign q_ready = !mv_reg || m_ready;
    assign take    = q_valid && q_ready;
    assign m_valid = mv_reg;
    assign m_data  = out_reg;

    // Next state for one item
    always_comb begin
        hs_next = hs_reg; fr_next = fr_reg; fin_next = fin_reg;
        pos_next = pos_reg; letter_next = letter_reg; hex_next = hex_reg;
        gv_next = gv_reg; err_next = err_reg; rej_next = rej_reg;
        cls_next = cls_reg; mode_next = mode_reg; den_next = den_reg;
        pfx_next = pfx_reg; ndone_next = ndone_reg; idle_next = idle_reg;
        emit = 1'b0; out_next = '0; match = 1'b0;
        c = q_data.ch; sub = pos_reg[1:0];
        slot = letter_slot(c); gslot = letter_slot(letter_reg);
        dprod = 20'(den_reg) * 20'd10 + 20'(c - 8'h30);
        if (q_data.cls == CL_START) begin
            hs_next = HS_NONE; fr_next = FR_IDLE; fin_next = 1'b0; idle_next = '0;
            pos_next = '0; letter_next = '0; hex_next = '0;
            for (int i = 0; i < 7; i++) gv_next[i] = NONE_VAL;
            err_next = '0; rej_next = '0; cls_next = '0; mode_next = '0;
            den_next = '0; pfx_next = 1'b1; ndone_next = 1'b0;
        end else if (!fin_reg && q_data.cls == CL_TICK) begin
            if (idle_reg != 16'hFFFF) idle_next = idle_reg + 16'd1;
            if (idle_next >= timeout_ticks) begin
                fin_next = 1'b1;
                emit = 1'b1;
                out_next.status_code = 3'(hs_reg) + 3'd1;
            end
        end else if (!fin_reg && q_data.cls != CL_NONE && q_data.cls != CL_TICK) begin
            idle_next = '0;
            // Handle the byte
            if (fr_reg == FR_CHECK) begin
                fr_next = FR_DONE;
            end else if (q_data.cls == CL_HS) begin
                hs_next = q_data.hs;
            end else if (q_data.cls == CL_STX) begin
                fr_next = FR_TEXT;
                pos_next = '0; letter_next = '0; hex_next = '0;
                for (int i = 0; i < 7; i++) gv_next[i] = NONE_VAL;
                err_next = '0; rej_next = '0; cls_next = '0; mode_next = '0;
                den_next = '0; pfx_next = 1'b1; ndone_next = 1'b0;
            end else if (q_data.cls == CL_ETX && fr_reg == FR_TEXT) begin
                fr_next = FR_CHECK;
            end else if (q_data.cls == CL_TEXT && fr_reg == FR_TEXT && pos_reg != 8'hFF) begin
                // Decode a kept character
                if (sub == 2'd0) begin
                    hex_next = '0;
                    letter_next = '0;
                    if (slot < SLOT_E) begin
                        gv_next[slot[2:0]] = '0;
                        letter_next = c;
                    end else if (slot == SLOT_E) begin
                        if (err_reg < ERR_MAX) begin
                            err_next = err_reg + 4'd1;
                            letter_next = c;
                        end
                    end else if (slot == SLOT_R) begin
                        if (rej_reg < REJ_MAX) rej_next = rej_reg + 2'd1;
                    end
                end else if (sub != 2'd3) begin
                    if (sub == 2'd1) hex_next = {hex_val(c), 4'd0};
                    else hex_next = hex_reg + 8'(hex_val(c));
                    if (gslot < SLOT_E) gv_next[gslot[2:0]] = hex_next;
                    else if (gslot == SLOT_E && sub == 2'd2)
                        cls_next = cls_reg | error_class_bit(hex_next);
                end
                if (pos_reg == 8'd1) mode_next[15:8] = c;
                if (pos_reg == 8'd2) mode_next[7:0] = c;
                if (pos_reg == 8'd0 && c != 8'h43) pfx_next = 1'b0;
                if (pos_reg == 8'd1 && c != 8'h4E) pfx_next = 1'b0;
                if (pos_reg == 8'd2 && c != 8'h59) pfx_next = 1'b0;
                if (pos_reg >= 8'd4 && !ndone_reg) begin
                    if (c >= 8'h30 && c <= 8'h39)
                        den_next = (dprod > 20'hFFFF) ? 16'hFFFF : dprod[15:0];
                    else
                        ndone_next = 1'b1;
                end
                pos_next = pos_reg + 8'd1;
            end
            // Check for the awaited reply
            unique case (expected_cmd)
                4'd1, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15: match = (hs_next == HS_DC1);
                4'd2, 4'd3, 4'd4, 4'd9, 4'd10:           match = (hs_next == HS_ACK);
                4'd5, 4'd7, 4'd8:                        match = (fr_next >= FR_CHECK);
                4'd6:    match = (fr_next >= FR_CHECK) && (pos_next != 8'd0);
                default: match = 1'b0;
            endcase
            if (match) begin
                fin_next = 1'b1;
                emit = 1'b1;
                out_next.accept_state  = gv_next[0];
                out_next.denom_index   = gv_next[1];
                out_next.note_count    = gv_next[3];
                out_next.misc_status   = {gv_next[2], gv_next[4], gv_next[5], gv_next[6]};
                out_next.error_classes = cls_next;
                out_next.error_count   = err_next;
                out_next.reject_count  = rej_next;
                out_next.work_mode     = mode_next;
                out_next.denomination  = (pos_next >= 8'd3 && pfx_next) ? den_next
                                                                          : EMPTY_DENOM;
            end
        end
    end

    // Parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hs_reg <= HS_NONE; fr_reg <= FR_IDLE; fin_reg <= 1'b1;
            pos_reg <= '0; letter_reg <= '0; hex_reg <= '0;
            for (int i = 0; i < 7; i++) gv_reg[i] <= NONE_VAL;
            err_reg <= '0; rej_reg <= '0; cls_reg <= '0; mode_reg <= '0;
            den_reg <= '0; pfx_reg <= 1'b1; ndone_reg <= 1'b0; idle_reg <= '0;
        end else if (take) begin
            hs_reg <= hs_next; fr_reg <= fr_next; fin_reg <= fin_next;
            pos_reg <= pos_next; letter_reg <= letter_next; hex_reg <= hex_next;
            gv_reg <= gv_next;
            err_reg <= err_next; rej_reg <= rej_next; cls_reg <= cls_next;
            mode_reg <= mode_next; den_reg <= den_next; pfx_reg <= pfx_next;
            ndone_reg <= ndone_next; idle_reg <= idle_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (take) begin
            mv_reg <= emit;
        end else if (m_ready) begin
            mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && emit) out_reg <= out_next;
    end

    `ASSERT_CLK(a_emit_sets_fin, aclk, aresetn, (take && emit) |=> fin_reg, "result without finish")
    `ASSERT_CLK(a_err_sat, aclk, aresetn, err_reg <= ERR_MAX, "error count above limit")
    `ASSERT_CLK(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> $stable(out_reg), "result changed while stalled")

endmodule

[design/bill_acceptor_reply_parser_top.sv]
// ----------------------------------------------------------------------------
// bill_acceptor_reply_parser_top
// Bill acceptor reply parser: byte-wise reply decode with match and timeout.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one item per handshake: op (byte, tick, start) and
//   rx_byte. m_ channel carries at most one result per item, when the awaited
//   reply arrives or the tick count reaches timeout_ticks.
//   cfg_we / cfg_index / cfg_data write expected_cmd (0) and timeout_ticks (1).
//   An item enters a two-entry queue; the parse stage takes it from the
//   queue and loads its result into the output register in that same
//   cycle, and the output register drives m_valid.
//   Throughput: one item per cycle while no result is held or m_ready is high.
//   After reset the parser is finished: only a start item begins a
//   transaction; registers reset to expected_cmd 1, timeout_ticks 1000.
//   When m_ready is low the result holds, the parse stage stops and the queue
//   fills, then s_ready drops.
// ----------------------------------------------------------------------------
module bill_acceptor_reply_parser_top
    import barp_pkg::*;
#(
    parameter int MAX_ERROR_ENTRIES  = MAX_ERROR_ENTRIES_DEF,
    parameter int MAX_REJECT_ENTRIES = MAX_REJECT_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    logic [3:0]  cmd_reg;
    logic [15:0] tmo_reg;
    logic        q_valid, q_ready;
    cls_item_t   q_data;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg <= 4'd1;
            tmo_reg <= 16'd1000;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_EXPECTED_CMD:  cmd_reg <= cfg_data[3:0];
                CFG_TIMEOUT_TICKS: tmo_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    barp_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    barp_back #(
        .MAX_ERROR_ENTRIES  (MAX_ERROR_ENTRIES),
        .MAX_REJECT_ENTRIES (MAX_REJECT_ENTRIES)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .expected_cmd  (cmd_reg),
        .timeout_ticks (tmo_reg),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_data        (q_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );

endmodule
